// File: rtl/grpd_pkg.sv
// Shared types, constants and the palette blend function of the glyph run pixel decoder.
package grpd_pkg;

  localparam int CODE_W      = 8;
  localparam int COLOR_W     = 16;
  localparam int LEVEL_W     = 2;
  localparam int COUNT_W     = 6;
  localparam int CFG_INDEX_W = 8;
  localparam int QUEUE_DEPTH = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 8'd1;

  localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 16'hFFFF;
  localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 16'h0000;

  // Mode codes in bits 7..6 of a code byte.
  localparam logic [1:0] MODE_RUN_BACK = 2'd0;
  localparam logic [1:0] MODE_RUN_FORE = 2'd3;

  // Pixels in a packed byte.
  localparam logic [COUNT_W-1:0] PACKED_PIXELS = 6'd4;

  // Blend weights in sixteenths for palette entries 0 to 3.
  localparam logic [4:0] BLEND_WEIGHT [4] = '{5'd0, 5'd5, 5'd10, 5'd16};
  localparam logic [4:0] BLEND_FULL = 5'd16;

  // One unit of work for the pixel stage. The four 2-bit levels rotate left by
  // one field per pixel; a run repeats its level in all four fields.
  typedef struct packed {
    logic [CODE_W-1:0]  levels;
    logic [COUNT_W-1:0] count;
  } grpd_cmd_t;

  // Mixes background and foreground with 8-bit channels and truncates to RGB565.
  function automatic logic [COLOR_W-1:0] blend_565(input logic [COLOR_W-1:0] back,
                                                   input logic [COLOR_W-1:0] fore,
                                                   input logic [LEVEL_W-1:0] level);
    logic [11:0] w;
    logic [11:0] wi;
    logic [11:0] r;
    logic [11:0] g;
    logic [11:0] b;
    w  = {7'd0, BLEND_WEIGHT[level]};
    wi = {7'd0, BLEND_FULL} - w;
    r  = wi * {4'd0, back[15:11], 3'b000} + w * {4'd0, fore[15:11], 3'b000};
    g  = wi * {4'd0, back[10:5], 2'b00} + w * {4'd0, fore[10:5], 2'b00};
    b  = wi * {4'd0, back[4:0], 3'b000} + w * {4'd0, fore[4:0], 3'b000};
    return {r[11:7], g[11:6], b[11:7]};
  endfunction

endpackage

// File: rtl/grpd_if.sv
// Handshake interfaces for the code, pixel and configuration channels.
interface grpd_code_if import grpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_byte;
  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);
endinterface

interface grpd_pixel_if import grpd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;
  logic [LEVEL_W-1:0] pixel_level;
  logic               last_of_byte;
  modport source (output valid, output pixel_color, output pixel_level,
                  output last_of_byte, input ready);
  modport sink (input valid, input pixel_color, input pixel_level,
                input last_of_byte, output ready);
endinterface

interface grpd_cfg_if import grpd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [COLOR_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/grpd_front.sv
// Front stage: classifies code bytes into pixel commands and drops empty runs.
module grpd_front import grpd_pkg::*; (
  grpd_code_if.sink code,
  output logic      cmd_valid,
  input  logic      cmd_ready,
  output grpd_cmd_t cmd
);

  logic [1:0] mode;
  logic       is_run;

  assign mode   = code.code_byte[7:6];
  assign is_run = (mode == MODE_RUN_BACK) || (mode == MODE_RUN_FORE);

  always_comb begin
    if (is_run) begin
      cmd.levels = {4{mode}};
      cmd.count  = code.code_byte[COUNT_W-1:0];
    end else begin
      cmd.levels = code.code_byte;
      cmd.count  = PACKED_PIXELS;
    end
  end

  // A run of length zero is consumed without producing a command.
  assign code.ready = cmd_ready;
  assign cmd_valid  = code.valid && (cmd.count != '0);

endmodule

// File: rtl/grpd_queue.sv
// Small register queue of pixel commands between the front and the pixel stage.
module grpd_queue import grpd_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  grpd_cmd_t push_cmd,
  output logic      pop_valid,
  input  logic      pop_ready,
  output grpd_cmd_t pop_cmd
);

  localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0]   LastPtr = PtrW'(Depth - 1);
  localparam logic [CountW-1:0] Full    = CountW'(Depth);

  grpd_cmd_t          entries [Depth];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [CountW-1:0]  fill;
  logic               push;
  logic               pop;

  assign push_ready = (fill != Full);
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: rtl/grpd_back.sv
// Pixel stage: steps a command to an output register a pixel a cycle unless stalled.
module grpd_back import grpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  grpd_cmd_t          cmd,
  input  logic [COLOR_W-1:0] foreground_color,
  input  logic [COLOR_W-1:0] background_color,
  grpd_pixel_if.source       pixel
);

  logic               active;
  logic [COUNT_W-1:0] remain;
  logic [CODE_W-1:0]  levels;
  logic               advance;
  logic               last;
  logic [LEVEL_W-1:0] level;

  assign advance   = !pixel.valid || pixel.ready;
  assign last      = (remain == COUNT_W'(1));
  assign level     = levels[CODE_W-1 -: LEVEL_W];
  assign cmd_ready = !active || (advance && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      pixel.valid <= 1'b0;
    end else begin
      if (advance) begin
        pixel.valid <= active;
      end
      if (cmd_valid && cmd_ready) begin
        active <= 1'b1;
      end else if (active && advance && last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      remain <= cmd.count;
      levels <= cmd.levels;
    end else if (active && advance) begin
      remain <= remain - 1'b1;
      levels <= {levels[CODE_W-LEVEL_W-1:0], levels[CODE_W-1 -: LEVEL_W]};
    end
    if (active && advance) begin
      pixel.pixel_color  <= blend_565(background_color, foreground_color, level);
      pixel.pixel_level  <= level;
      pixel.last_of_byte <= last;
    end
  end

endmodule

// File: rtl/glyph_run_pixel_decoder_core.sv
// Top level of the glyph run pixel decoder: configuration registers and the three stages.
//
// The code channel takes one byte of compressed glyph data per request. Modes 0 and 3
// give a run of (byte AND 63) pixels of palette entry 0 or 3; a zero count gives none.
// Modes 1 and 2 give four pixels from the 2-bit fields, most significant first.
// The pixel channel carries one RGB565 color per request, with its palette level and
// a flag on the last pixel of each byte.
// The cfg channel writes foreground_color (index 0) and background_color (index 1);
// other indexes are ignored. It is always ready and is meant to be used while idle.
// The palette color is blended from the two registers as each pixel is produced.
// A byte's pixels pass a queue entry, the pixel stage registers and the output register.
// Throughput: the pixel stage produces one pixel per cycle while the receiver takes
// them, and it works through the pixels of each byte (four for a packed byte, 1 to 63
// for a run); empty runs are dropped at the front. The command queue lets the front
// take further bytes while the pixel stage works.
// When the receiver stalls, the output register holds its pixel and the pixel stage
// waits; the queue fills and then the code channel drops ready.
// Reset clears the queue and the valid flags and sets the colors to white on black.
module glyph_run_pixel_decoder_core import grpd_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  grpd_code_if.sink  code,
  grpd_pixel_if.source pixel,
  grpd_cfg_if.sink   cfg
);

  logic [COLOR_W-1:0] foreground_color;
  logic [COLOR_W-1:0] background_color;

  logic      front_valid;
  logic      front_ready;
  grpd_cmd_t front_cmd;
  logic      back_valid;
  logic      back_ready;
  grpd_cmd_t back_cmd;

  // Configuration writes complete in the cycle they are presented.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      foreground_color <= FOREGROUND_RESET;
      background_color <= BACKGROUND_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_FOREGROUND) begin
        foreground_color <= cfg.data;
      end else if (cfg.index == REG_BACKGROUND) begin
        background_color <= cfg.data;
      end
    end
  end

  grpd_front u_front (
    .code      (code),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  grpd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  grpd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cmd_valid        (back_valid),
    .cmd_ready        (back_ready),
    .cmd              (back_cmd),
    .foreground_color (foreground_color),
    .background_color (background_color),
    .pixel            (pixel)
  );

endmodule

// File: tb/sv/glyph_run_pixel_decoder_core_tb.sv
// Self-checking testbench for the glyph run pixel decoder core: palette colors, run and packed bytes.
module glyph_run_pixel_decoder_core_tb;
  import grpd_pkg::*;

  // Blend weights of the four palette entries, in sixteenths.
  localparam int unsigned MIX_WEIGHT [4] = '{0, 5, 10, 16};

  // The two packed modes; the run modes come from the package.
  localparam logic [1:0] MODE_PACKED_LO = 2'd1;
  localparam logic [1:0] MODE_PACKED_HI = 2'd2;

  localparam int unsigned PHASES          = 6;
  localparam int unsigned ITEMS_PER_PHASE = 44;
  // Cycles allowed for an empty run to leave the front after the last pixel has come.
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned END_CYCLES      = 10;
  // The longest quiet stretch is a long sender or receiver gap plus the settle time, so
  // this leaves a wide margin.
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned PRINT_CAP       = 40;

  typedef enum logic {ROW_CODE, ROW_CFG} row_kind_t;

  // One directed row. For a code row, value is the byte, and data is the color that every
  // pixel of the byte must have when typed is set. For a config row, value is the register
  // index and data the value written.
  typedef struct packed {
    row_kind_t          kind;
    logic [7:0]         value;
    logic [COLOR_W-1:0] data;
    logic               typed;
  } stim_row_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } pixel_t;

  localparam int unsigned DIRECTED_ROWS = 25;

  // After reset the colors are white on black, so run pixels are plainly black or white.
  // The packed rows are left to the predictor.
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_CODE, 8'h00, 16'h0000, 1'b1},   // empty background run
    '{ROW_CODE, 8'hC0, 16'h0000, 1'b1},   // empty foreground run
    '{ROW_CODE, 8'h01, 16'h0000, 1'b1},
    '{ROW_CODE, 8'hC1, 16'hFFFF, 1'b1},
    '{ROW_CODE, 8'h3F, 16'h0000, 1'b1},   // longest background run
    '{ROW_CODE, 8'hFF, 16'hFFFF, 1'b1},   // longest foreground run
    '{ROW_CODE, 8'h40, 16'h0000, 1'b0},
    '{ROW_CODE, 8'h7F, 16'h0000, 1'b0},
    '{ROW_CODE, 8'h80, 16'h0000, 1'b0},
    '{ROW_CODE, 8'hBF, 16'h0000, 1'b0},
    '{ROW_CODE, 8'h55, 16'h0000, 1'b0},
    '{ROW_CODE, 8'hAA, 16'h0000, 1'b0},
    '{ROW_CODE, 8'h6C, 16'h0000, 1'b0},
    '{ROW_CODE, 8'h93, 16'h0000, 1'b0},
    '{ROW_CODE, 8'h1B, 16'h0000, 1'b1},
    '{ROW_CODE, 8'hE4, 16'hFFFF, 1'b1},
    '{ROW_CFG,  8'h02, 16'h1234, 1'b0},   // index past the register list, ignored
    '{ROW_CFG,  8'hFF, 16'h0000, 1'b0},   // same, all index bits high
    '{ROW_CODE, 8'hC2, 16'hFFFF, 1'b1},   // colors must be unchanged
    '{ROW_CODE, 8'h02, 16'h0000, 1'b1},
    '{ROW_CFG,  REG_FOREGROUND, 16'h0000, 1'b0},
    '{ROW_CFG,  REG_BACKGROUND, 16'hFFFF, 1'b0},
    '{ROW_CODE, 8'hC3, 16'h0000, 1'b1},   // inverted: font black on white
    '{ROW_CODE, 8'h03, 16'hFFFF, 1'b1},
    '{ROW_CODE, 8'h5A, 16'h0000, 1'b0}
  };

  logic clk;
  logic rst;

  grpd_code_if  code_if ();
  grpd_pixel_if pixel_if ();
  grpd_cfg_if   cfg_if ();

  glyph_run_pixel_decoder_core u_top (
    .clk   (clk),
    .rst   (rst),
    .code  (code_if),
    .pixel (pixel_if),
    .cfg   (cfg_if)
  );

  // The predictor's copy of the two color registers.
  logic [COLOR_W-1:0] font_color_model;
  logic [COLOR_W-1:0] back_color_model;

  // Pixels still owed by the block, oldest first.
  pixel_t pending_pixels [$];

  // Typed expectation that travels with the byte currently offered.
  logic               row_typed;
  logic [COLOR_W-1:0] row_typed_color;

  int unsigned code_accepts;
  int unsigned cfg_accepts;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  bit          free_run;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mixes background and font color for one palette level. Each channel is widened to
  // 8 bits with its bits at the top, weighted in sixteenths, and cut back to RGB565.
  function automatic logic [COLOR_W-1:0] palette_color(input logic [COLOR_W-1:0] back,
                                                       input logic [COLOR_W-1:0] fore,
                                                       input logic [LEVEL_W-1:0] level);
    logic [31:0] w;
    logic [31:0] r;
    logic [31:0] g;
    logic [31:0] b;
    w = MIX_WEIGHT[level];
    r = ((32'd16 - w) * {back[15:11], 3'b000} + w * {fore[15:11], 3'b000}) >> 4;
    g = ((32'd16 - w) * {back[10:5], 2'b00} + w * {fore[10:5], 2'b00}) >> 4;
    b = ((32'd16 - w) * {back[4:0], 3'b000} + w * {fore[4:0], 3'b000}) >> 4;
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // Queues the pixels that one accepted byte must produce.
  task automatic queue_byte_pixels(input logic [CODE_W-1:0] code_byte, input logic typed,
                                   input logic [COLOR_W-1:0] typed_color);
    logic [1:0]   mode;
    logic [5:0]   count;
    logic [CODE_W-1:0] fields;
    pixel_t       px;
    mode = code_byte[7:6];
    count = code_byte[5:0];
    if (mode == MODE_RUN_BACK || mode == MODE_RUN_FORE) begin
      // A run repeats its mode as the level; a zero count gives nothing at all.
      for (int i = 0; i < count; i++) begin
        px.level = mode;
        px.color = typed ? typed_color
                         : palette_color(back_color_model, font_color_model, mode);
        px.last  = (i + 1 == count);
        pending_pixels.push_back(px);
      end
    end else begin
      // Packed: four levels, most significant field first.
      fields = code_byte;
      for (int i = 0; i < 4; i++) begin
        px.level = fields[7:6];
        px.color = palette_color(back_color_model, font_color_model, fields[7:6]);
        px.last  = (i == 3);
        pending_pixels.push_back(px);
        fields = fields << 2;
      end
    end
  endtask

  // Prints one line per mismatch and counts it. Printing stops after a cap so that a
  // badly broken block does not flood the log, but the count keeps going.
  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  // Monitor: everything is sampled at the rising edge, the state the block had just
  // before the edge.
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      font_color_model <= FOREGROUND_RESET;
      back_color_model <= BACKGROUND_RESET;
    end else begin
      // Check the pixel first; a byte taken at this edge cannot have produced it yet.
      if (pixel_if.valid && pixel_if.ready) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel color %h level %0d last %b",
                                    pixel_if.pixel_color, pixel_if.pixel_level,
                                    pixel_if.last_of_byte));
        end else begin
          want = pending_pixels.pop_front();
          if (pixel_if.pixel_color !== want.color)
            report_mismatch($sformatf("pixel_color %h, expected %h",
                                      pixel_if.pixel_color, want.color));
          if (pixel_if.pixel_level !== want.level)
            report_mismatch($sformatf("pixel_level %0d, expected %0d",
                                      pixel_if.pixel_level, want.level));
          if (pixel_if.last_of_byte !== want.last)
            report_mismatch($sformatf("last_of_byte %b, expected %b",
                                      pixel_if.last_of_byte, want.last));
        end
      end
      if (code_if.valid && code_if.ready) begin
        queue_byte_pixels(code_if.code_byte, row_typed, row_typed_color);
        code_accepts <= code_accepts + 1;
      end
      // Register writes happen only while idle, so they never race a byte above.
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == REG_FOREGROUND) font_color_model <= cfg_if.data;
        else if (cfg_if.index == REG_BACKGROUND) back_color_model <= cfg_if.data;
        cfg_accepts <= cfg_accepts + 1;
      end
    end
  end

  // Watchdog: ends the run if no request moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (code_if.valid && code_if.ready) || (pixel_if.valid && pixel_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("** glyph_run_pixel_decoder_core: FAILED **");
        $finish;
      end
    end
  end

  // Gap lengths: mostly short, now and then a long one.
  function automatic int unsigned gap_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: ready changes at the falling edge and drops for random stretches,
  // except during the free-running phase.
  int unsigned sink_hold;
  always @(negedge clk) begin
    if (rst) begin
      pixel_if.ready = 1'b0;
      sink_hold = 0;
    end else if (sink_hold > 0) begin
      pixel_if.ready = 1'b0;
      sink_hold--;
    end else begin
      pixel_if.ready = 1'b1;
      if (!free_run && $urandom_range(0, 99) < 20) sink_hold = gap_length();
    end
  end

  // Offers one byte and returns at the falling edge after it was taken, valid still high.
  task automatic send_code(input logic [CODE_W-1:0] code_byte, input logic typed,
                           input logic [COLOR_W-1:0] typed_color);
    int unsigned seen;
    seen = code_accepts;
    code_if.code_byte = code_byte;
    row_typed = typed;
    row_typed_color = typed_color;
    code_if.valid = 1'b1;
    do @(negedge clk); while (code_accepts == seen);
  endtask

  task automatic sender_pause();
    if (!free_run && $urandom_range(0, 99) < 30) begin
      code_if.valid = 1'b0;
      repeat (gap_length()) @(negedge clk);
    end
  endtask

  // Waits until every owed pixel has come, then gives an empty run time to clear.
  task automatic drain_pixels();
    code_if.valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [COLOR_W-1:0] data);
    int unsigned seen;
    seen = cfg_accepts;
    cfg_if.index = index;
    cfg_if.data = data;
    cfg_if.valid = 1'b1;
    do @(negedge clk); while (cfg_accepts == seen);
    cfg_if.valid = 1'b0;
  endtask

  // Random byte: half packed, most runs short, a fifth of them any length.
  function automatic logic [CODE_W-1:0] random_code();
    int unsigned pick;
    logic [1:0]  mode;
    logic [5:0]  low;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      mode = $urandom_range(0, 1) ? MODE_PACKED_HI : MODE_PACKED_LO;
      low = 6'($urandom);
    end else begin
      mode = $urandom_range(0, 1) ? MODE_RUN_FORE : MODE_RUN_BACK;
      low = (pick < 90) ? 6'($urandom_range(0, 8)) : 6'($urandom_range(0, 63));
    end
    return {mode, low};
  endfunction

  initial begin
    logic [COLOR_W-1:0] font_setting;
    logic [COLOR_W-1:0] back_setting;
    code_accepts = 0;
    cfg_accepts = 0;
    mismatch_count = 0;
    quiet_cycles = 0;
    free_run = 1'b0;
    row_typed = 1'b0;
    row_typed_color = '0;
    code_if.valid = 1'b0;
    code_if.code_byte = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    pixel_if.ready = 1'b0;
    rst = 1'b1;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Directed part: register writes wait for the block to go idle first.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        drain_pixels();
        write_register(DIRECTED[i].value, DIRECTED[i].data);
      end else begin
        send_code(DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].data);
        sender_pause();
      end
    end

    // Random part, one color setting per phase. The first phases use the extremes and
    // a split of pure red font on pure green background; the rest are random.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          font_setting = 16'hF800;
          back_setting = 16'h07E0;
        end
        1: begin
          font_setting = 16'hFFFF;
          back_setting = 16'hFFFF;
        end
        2: begin
          font_setting = 16'h0000;
          back_setting = 16'h0000;
        end
        default: begin
          font_setting = COLOR_W'($urandom);
          back_setting = COLOR_W'($urandom);
        end
      endcase
      drain_pixels();
      write_register(REG_FOREGROUND, font_setting);
      write_register(REG_BACKGROUND, back_setting);
      // A stray write past the register list now and then must change nothing.
      if ($urandom_range(0, 1))
        write_register(CFG_INDEX_W'($urandom_range(2, 255)), COLOR_W'($urandom));
      // One phase runs with no idling on either side.
      free_run = (p == 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Halfway through one phase the sender holds off until the block has emptied.
        if (p == 3 && n == ITEMS_PER_PHASE / 2) drain_pixels();
        send_code(random_code(), 1'b0, '0);
        sender_pause();
      end
    end

    free_run = 1'b0;
    code_if.valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (END_CYCLES) @(negedge clk);
    if (pending_pixels.size() != 0)
      report_mismatch($sformatf("%0d pixels never came", pending_pixels.size()));

    if (mismatch_count == 0) begin
      $display("** glyph_run_pixel_decoder_core: PASSED **");
    end else begin
      $display("** glyph_run_pixel_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule
